// File: rtl/core/tss_pkg.sv
// tss_pkg: shared types and codes for the topological sorter.
// Request/result payloads, request kind codes, memory control groups.
// No dependencies.
package tss_pkg;

	localparam int VCOUNT_W = 7;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_EDGE  = 2'd1;
	localparam logic [1:0] KIND_RUN   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] from_vertex;
		logic [5:0] to_vertex;
	} request_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic       cycle_found;
		logic       last;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} adj_ctl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} deg_ctl_t;

endpackage

// File: rtl/core/tss_adj_mem.sv
// tss_adj_mem: adjacency matrix, one row per source vertex, registered read.
// Per-row valid bits give an all-zero graph after reset or clear.
// Depends on tss_pkg.
module tss_adj_mem
	import tss_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adj_ctl_t                ctl,
	input  logic [AW-1:0]           rd_addr,
	input  logic [AW-1:0]           wr_addr,
	input  logic [MAX_VERTICES-1:0] wr_data,
	output logic [MAX_VERTICES-1:0] rd_data
);

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] rd_row_q;
	logic                    rd_ok_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (ctl.clear) begin
				row_valid_q <= '0;
			end else if (ctl.wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_ok_q <= row_valid_q[rd_addr];
			end
		end
	end

	// stale rows of a cleared graph read as empty
	assign rd_data = rd_ok_q ? rd_row_q : '0;

endmodule

// File: rtl/core/tss_deg_mem.sv
// tss_deg_mem: working in-degree store, one write and one read port.
// Read data registered; contents undefined until a run writes them.
// Depends on tss_pkg.
module tss_deg_mem
	import tss_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic          clk,
	input  deg_ctl_t      ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [CW-1:0] wr_data,
	output logic [CW-1:0] rd_data
);

	logic [CW-1:0] mem [MAX_VERTICES];
	logic [CW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/core/tss_seq.sv
// tss_seq: request sequencer; clear, edge insert, in-degree pass, search/decrement.
// Drives tss_adj_mem and tss_deg_mem, registers the result strobe.
// Depends on tss_pkg.
module tss_seq
	import tss_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  request_t                request,
	input  logic [AW-1:0]           n_m1,
	output logic                    busy,
	output adj_ctl_t                adj_ctl,
	output logic [AW-1:0]           adj_rd_addr,
	output logic [AW-1:0]           adj_wr_addr,
	output logic [MAX_VERTICES-1:0] adj_wr_data,
	input  logic [MAX_VERTICES-1:0] adj_rd_data,
	output deg_ctl_t                deg_ctl,
	output logic [AW-1:0]           deg_rd_addr,
	output logic [AW-1:0]           deg_wr_addr,
	output logic [CW-1:0]           deg_wr_data,
	input  logic [CW-1:0]           deg_rd_data,
	output logic                    strobe,
	output result_t                 result
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_EDGE_WR   = 3'd1;
	localparam logic [2:0] ST_DEG       = 3'd2;
	localparam logic [2:0] ST_DEG_DRAIN = 3'd3;
	localparam logic [2:0] ST_SEARCH    = 3'd4;
	localparam logic [2:0] ST_ROWRD     = 3'd5;
	localparam logic [2:0] ST_DEC       = 3'd6;
	localparam logic [2:0] ST_DEC_DRAIN = 3'd7;

	logic [2:0]              state_q;
	logic [AW-1:0]           i_q, j_q, k_q, v_q, count_q;
	logic [AW-1:0]           from_q, to_q;
	logic                    iss_q;
	logic [MAX_VERTICES-1:0] emitted_q;
	logic [CW-1:0]           acc_q;

	logic                    dg_v_s1, dg_first_s1, dg_last_s1;
	logic [AW-1:0]           dg_col_s1;
	logic                    sr_v_s1;
	logic [AW-1:0]           sr_k_s1;
	logic                    dc_v_s1;
	logic [AW-1:0]           dc_j_s1;

	logic                    strobe_q;
	result_t                 result_q;

	logic                    accept, in_range, sr_hit, sr_miss, hit_last;
	logic [CW-1:0]           dg_acc;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = (7'(request.from_vertex) <= 7'(n_m1))
		&& (7'(request.to_vertex) <= 7'(n_m1));
	assign dg_acc   = (dg_first_s1 ? '0 : acc_q) + CW'(adj_rd_data[dg_col_s1]);
	assign sr_hit   = sr_v_s1 && (deg_rd_data == '0) && !emitted_q[sr_k_s1];
	assign sr_miss  = sr_v_s1 && !sr_hit && (sr_k_s1 == n_m1);
	assign hit_last = (count_q == n_m1);

	always_comb begin
		adj_ctl     = '0;
		adj_rd_addr = j_q;
		adj_wr_addr = from_q;
		adj_wr_data = adj_rd_data | (MAX_VERTICES'(1) << to_q);
		deg_ctl     = '0;
		deg_rd_addr = j_q;
		deg_wr_addr = dg_col_s1;
		deg_wr_data = dg_acc;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && request.kind == KIND_CLEAR) begin
					adj_ctl.clear = 1'b1;
				end
				if (accept && request.kind == KIND_EDGE && in_range) begin
					adj_ctl.rd_en = 1'b1;
					adj_rd_addr   = request.from_vertex[AW-1:0];
				end
			end
			ST_EDGE_WR: adj_ctl.wr_en = 1'b1;
			ST_DEG:     adj_ctl.rd_en = 1'b1;
			ST_ROWRD: begin
				adj_ctl.rd_en = 1'b1;
				adj_rd_addr   = v_q;
			end
			ST_SEARCH: begin
				deg_ctl.rd_en = iss_q;
				deg_rd_addr   = k_q;
			end
			ST_DEC: deg_ctl.rd_en = 1'b1;
			default: ;
		endcase
		// stage-1 write back: column total, or successor decrement
		if (dg_v_s1 && dg_last_s1) begin
			deg_ctl.wr_en = 1'b1;
		end else if (dc_v_s1 && adj_rd_data[dc_j_s1] && deg_rd_data != '0) begin
			deg_ctl.wr_en = 1'b1;
			deg_wr_addr   = dc_j_s1;
			deg_wr_data   = deg_rd_data - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			count_q   <= '0;
			iss_q     <= 1'b0;
			emitted_q <= '0;
			dg_v_s1   <= 1'b0;
			sr_v_s1   <= 1'b0;
			dc_v_s1   <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			dg_v_s1  <= (state_q == ST_DEG);
			dc_v_s1  <= (state_q == ST_DEC);
			sr_v_s1  <= (state_q == ST_SEARCH) && iss_q && !sr_hit && !sr_miss;
			strobe_q <= sr_hit || sr_miss;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (request.kind)
							KIND_EDGE: begin
								if (in_range) begin
									state_q <= ST_EDGE_WR;
								end
							end
							KIND_RUN: begin
								state_q   <= ST_DEG;
								i_q       <= '0;
								j_q       <= '0;
								count_q   <= '0;
								emitted_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_EDGE_WR: state_q <= ST_IDLE;
				ST_DEG: begin
					if (j_q == n_m1) begin
						j_q <= '0;
						if (i_q == n_m1) begin
							state_q <= ST_DEG_DRAIN;
						end else begin
							i_q <= i_q + AW'(1);
						end
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_DEG_DRAIN, ST_DEC_DRAIN: begin
					state_q <= ST_SEARCH;
					k_q     <= '0;
					iss_q   <= 1'b1;
				end
				ST_SEARCH: begin
					if (iss_q) begin
						if (k_q == n_m1) begin
							iss_q <= 1'b0;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
					if (sr_hit) begin
						emitted_q[sr_k_s1] <= 1'b1;
						count_q            <= count_q + AW'(1);
						iss_q              <= 1'b0;
						state_q            <= hit_last ? ST_IDLE : ST_ROWRD;
					end else if (sr_miss) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ROWRD: begin
					state_q <= ST_DEC;
					j_q     <= '0;
				end
				ST_DEC: begin
					if (j_q == n_m1) begin
						state_q <= ST_DEC_DRAIN;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			from_q <= request.from_vertex[AW-1:0];
			to_q   <= request.to_vertex[AW-1:0];
		end
		if (sr_hit) begin
			v_q <= sr_k_s1;
		end
		if (dg_v_s1) begin
			acc_q <= dg_acc;
		end
		dg_col_s1   <= i_q;
		dg_first_s1 <= (j_q == '0);
		dg_last_s1  <= (j_q == n_m1);
		sr_k_s1     <= k_q;
		dc_j_s1     <= j_q;
		if (sr_hit) begin
			result_q.vertex      <= 6'(sr_k_s1);
			result_q.cycle_found <= 1'b0;
			result_q.last        <= hit_last;
		end else if (sr_miss) begin
			result_q.vertex      <= '0;
			result_q.cycle_found <= 1'b1;
			result_q.last        <= 1'b1;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTH
	a_emit_marked: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.cycle_found |-> emitted_q[result_q.vertex[AW-1:0]])
		else $error("emitted vertex not flagged");
	a_mid_row_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |-> state_q == ST_ROWRD)
		else $error("non-final result not followed by row read");
	a_adj_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		adj_ctl.wr_en |-> $past(adj_ctl.rd_en) && $past(state_q == ST_IDLE))
		else $error("edge write without preceding row read");
	a_deg_rw_split: assert property (@(posedge clk) disable iff (!arst_n)
		deg_ctl.wr_en && deg_ctl.rd_en |-> state_q == ST_DEC || state_q == ST_DEC_DRAIN
		|| state_q == ST_DEG_DRAIN || state_q == ST_DEG)
		else $error("in-degree read/write overlap outside pass");
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == ST_SEARCH))
		else $error("result strobe outside search");
`endif

endmodule

// File: rtl/core/topological_sort_source_removal.sv
// topological_sort_source_removal: Kahn topological sorter, top level.
// Holds the vertex_count register and instantiates tss_seq, tss_adj_mem
// and tss_deg_mem. Depends on tss_pkg.
//
// Usage:
//   Request channel: a request (kind, from_vertex, to_vertex) is taken on
//   a rising edge with start high and busy low.
//   - clear: empties the graph, busy stays low.
//   - add edge: read-modify-write of the source row, busy for one cycle;
//     edges with an end at or above the active vertex count are dropped.
//   - run: in-degree pass over the matrix (n = active count), one row read
//     per cycle. Then per emitted vertex: a search over the in-degree
//     memory, one row read, and a decrement pass over that row.
//   Result channel: strobe is high for one cycle per result; the receiver
//   cannot stall, results are separated by a row read and a decrement pass. The
//   final result of a run has last set; a cycle marker (vertex 0,
//   cycle_found set) ends a run early.
//   cfg_we/cfg_wdata write vertex_count; 0 acts as 1, values above
//   MAX_VERTICES act as MAX_VERTICES. Write only while busy is low.
//   Reset: graph empty, vertex_count = 64, sequencer idle. No clearing
//   pass is needed; row valid bits cover the empty graph.
module topological_sort_source_removal
	import tss_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  request_t            request,
	output logic                busy,
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_wdata,
	output logic                strobe,
	output result_t             result
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	logic [VCOUNT_W-1:0]     vertex_count_q;
	logic [AW-1:0]           n_m1;

	adj_ctl_t                adj_ctl;
	logic [AW-1:0]           adj_rd_addr, adj_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
	deg_ctl_t                deg_ctl;
	logic [AW-1:0]           deg_rd_addr, deg_wr_addr;
	logic [CW-1:0]           deg_wr_data, deg_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// highest active vertex index after clamping the count to 1..MAX
	always_comb begin
		priority if (vertex_count_q == '0) begin
			n_m1 = '0;
		end else if (vertex_count_q > VCOUNT_W'(MAX_VERTICES)) begin
			n_m1 = AW'(MAX_VERTICES - 1);
		end else begin
			n_m1 = AW'(vertex_count_q - VCOUNT_W'(1));
		end
	end

	tss_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.request     (request),
		.n_m1        (n_m1),
		.busy        (busy),
		.adj_ctl     (adj_ctl),
		.adj_rd_addr (adj_rd_addr),
		.adj_wr_addr (adj_wr_addr),
		.adj_wr_data (adj_wr_data),
		.adj_rd_data (adj_rd_data),
		.deg_ctl     (deg_ctl),
		.deg_rd_addr (deg_rd_addr),
		.deg_wr_addr (deg_wr_addr),
		.deg_wr_data (deg_wr_data),
		.deg_rd_data (deg_rd_data),
		.strobe      (strobe),
		.result      (result)
	);

	tss_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (adj_ctl),
		.rd_addr (adj_rd_addr),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data),
		.rd_data (adj_rd_data)
	);

	tss_deg_mem #(.MAX_VERTICES(MAX_VERTICES)) u_deg_mem (
		.clk     (clk),
		.ctl     (deg_ctl),
		.rd_addr (deg_rd_addr),
		.wr_addr (deg_wr_addr),
		.wr_data (deg_wr_data),
		.rd_data (deg_rd_data)
	);

endmodule
